FILE: rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg: shared definitions for the chunked body decoder
// Status codes, character constants, byte classifiers and the per-byte
// result record passed from the parser to the output stage.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [1:0] SKIP_AFTER_DATA = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_EOL    = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE  = 2'd2;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

    typedef struct packed {
        logic       emit;        // a result item comes out of this byte
        logic       data_valid;  // the byte is payload
        logic       body_done;   // the byte closes the body
        logic [1:0] status;      // final status, zero unless body_done
    } hcbd_result_t;

    // {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B)
            || (b == 8'h0C) || (b == 8'h0D);
    endfunction

endpackage

FILE: rtl/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core: HTTP/1.1 chunked body decoder
// Strips chunk size lines and trailing CR LF from a byte stream, passes the
// chunk payload through and reports a final status on the last body byte.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                                         | moves
//  --------+-----------+-----------------------------------------------+-------------------
//  s_      | in        | s_valid s_ready s_body_byte s_end_of_body     | one body byte
//  m_      | out       | m_valid m_ready m_data_byte m_data_valid      | payload byte and/or
//          |           | m_body_done m_status                          | final status
//
//  One body byte per cycle while the output is not stalled. A byte is parsed
//  in the cycle of its transfer and its result sits in the output register
//  from the next cycle on; the rate is set by the single framing-state update.
//  Bytes that yield no result (size lines, skipped CR LF, bytes after the end
//  of decoding) produce no output transfer.
//  aresetn is synchronous and active low; it clears the framing state and
//  the output valid flag.
//  A stalled output holds its register; input is taken whenever the output
//  register is empty or drains in the same cycle.
//
module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_body_byte,
    input  logic       s_end_of_body,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic       m_data_valid,
    output logic       m_body_done,
    output logic [1:0] m_status
);

    hcbd_pkg::hcbd_result_t result;

    logic       s_xfer;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] data_byte_reg;
    logic       data_valid_reg;
    logic       body_done_reg;
    logic [1:0] status_reg;

    // accept while the output register is free or drains this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    hcbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (s_xfer),
        .body_byte   (s_body_byte),
        .end_of_body (s_end_of_body),
        .result      (result)
    );

    // load on a transfer that emits, drop valid once the consumer takes it
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_xfer) begin
            m_valid_next = result.emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload register: hold while stalled
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            data_byte_reg  <= result.data_valid ? s_body_byte : 8'd0;
            data_valid_reg <= result.data_valid;
            body_done_reg  <= result.body_done;
            status_reg     <= result.status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data_byte  = data_byte_reg;
    assign m_data_valid = data_valid_reg;
    assign m_body_done  = body_done_reg;
    assign m_status     = status_reg;

endmodule

FILE: rtl/hcbd_parser.sv
// ----------------------------------------------------------------------------
// hcbd_parser: chunk framing state machine
// Advances the framing state by one body byte per accepted transfer and
// reports what result, if any, that byte produces.
// ----------------------------------------------------------------------------
module hcbd_parser #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            body_byte,
    input  logic                  end_of_body,
    output hcbd_pkg::hcbd_result_t result
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_DONE = 2'd2,
        PH_LINE = 2'd3
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] count_reg, count_next;
    logic                 seen_reg, seen_next;
    logic                 stopped_reg, stopped_next;
    logic                 cr_reg, cr_next;
    logic                 ovf_reg, ovf_next;
    logic [1:0]           skip_reg, skip_next;

    always_comb begin
        logic [SIZE_BITS-1:0] base;
        logic [4:0]           hx;
        logic                 in_line;

        phase_next   = phase_reg;
        count_next   = count_reg;
        seen_next    = seen_reg;
        stopped_next = stopped_reg;
        cr_next      = cr_reg;
        ovf_next     = ovf_reg;
        skip_next    = skip_reg;
        result       = '0;

        hx      = hcbd_pkg::hex_decode(body_byte);
        in_line = 1'b0;
        base    = count_reg;

        unique case (phase_reg)
            PH_IDLE: begin
                if (skip_reg != 2'd0) begin
                    skip_next = skip_reg - 2'd1;
                end else begin
                    in_line = 1'b1;
                    base    = '0;
                end
            end
            PH_LINE: begin
                in_line = 1'b1;
            end
            PH_DATA: begin
                result.data_valid = 1'b1;
                count_next        = count_reg - SIZE_BITS'(1);
                if (count_next == '0) begin
                    phase_next = PH_IDLE;
                    skip_next  = hcbd_pkg::SKIP_AFTER_DATA;
                end
            end
            default: ;
        endcase

        // size line byte
        if (in_line) begin
            phase_next = PH_LINE;
            count_next = base;
            if (body_byte == hcbd_pkg::CHAR_LF && cr_reg) begin
                cr_next      = 1'b0;
                seen_next    = 1'b0;
                stopped_next = 1'b0;
                if (!seen_reg || ovf_reg) begin
                    ovf_next   = 1'b1;
                    phase_next = PH_DONE;
                end else if (base == '0) begin
                    ovf_next   = 1'b0;
                    phase_next = PH_DONE;
                end else begin
                    phase_next = PH_DATA;
                end
            end else begin
                cr_next = (body_byte == hcbd_pkg::CHAR_CR);
                if (!stopped_reg) begin
                    if (hx[4]) begin
                        seen_next = 1'b1;
                        if (!ovf_reg) begin
                            if (base[SIZE_BITS-1 -: 4] != 4'd0) begin
                                ovf_next = 1'b1;
                            end else begin
                                count_next = {base[SIZE_BITS-5:0], hx[3:0]};
                            end
                        end
                    end else if (seen_reg || !hcbd_pkg::is_space(body_byte)) begin
                        stopped_next = 1'b1;
                    end
                end
            end
        end

        result.body_done = end_of_body;
        result.emit      = result.data_valid || end_of_body;
        if (end_of_body) begin
            unique case (phase_next)
                PH_LINE: result.status = hcbd_pkg::STATUS_NO_EOL;
                PH_DATA: result.status = hcbd_pkg::STATUS_TRUNCATED;
                PH_DONE: result.status = ovf_next ? hcbd_pkg::STATUS_BAD_SIZE
                                                  : hcbd_pkg::STATUS_OK;
                default: result.status = hcbd_pkg::STATUS_OK;
            endcase
            // start the next body from a clean state
            phase_next   = PH_IDLE;
            count_next   = '0;
            seen_next    = 1'b0;
            stopped_next = 1'b0;
            cr_next      = 1'b0;
            ovf_next     = 1'b0;
            skip_next    = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            seen_reg    <= 1'b0;
            stopped_reg <= 1'b0;
            cr_reg      <= 1'b0;
            ovf_reg     <= 1'b0;
            skip_reg    <= 2'd0;
        end else if (step) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            seen_reg    <= seen_next;
            stopped_reg <= stopped_next;
            cr_reg      <= cr_next;
            ovf_reg     <= ovf_next;
            skip_reg    <= skip_next;
        end
    end

endmodule
